FILE: sv/owm_pkg.sv
package owm_pkg;

  localparam int TIMER_BITS_DEF = 10;
  localparam int CFG_W          = 10;
  localparam int NUM_REGS       = 8;
  localparam int ADDR_W         = 5;

  typedef logic [CFG_W-1:0] cfg_word_t;

  typedef struct packed {
    cfg_word_t reset_idle_time;
    cfg_word_t reset_low_time;
    cfg_word_t presence_sample_time;
    cfg_word_t reset_recovery_time;
    cfg_word_t short_low_time;
    cfg_word_t zero_low_time;
    cfg_word_t read_sample_time;
    cfg_word_t slot_time;
  } cfg_t;

  localparam logic [2:0] REG_RESET_IDLE   = 3'd0;
  localparam logic [2:0] REG_RESET_LOW    = 3'd1;
  localparam logic [2:0] REG_PRESENCE     = 3'd2;
  localparam logic [2:0] REG_RECOVERY     = 3'd3;
  localparam logic [2:0] REG_SHORT_LOW    = 3'd4;
  localparam logic [2:0] REG_ZERO_LOW     = 3'd5;
  localparam logic [2:0] REG_READ_SAMPLE  = 3'd6;
  localparam logic [2:0] REG_SLOT         = 3'd7;

  localparam cfg_word_t RST_RESET_IDLE  = 10'd10;
  localparam cfg_word_t RST_RESET_LOW   = 10'd480;
  localparam cfg_word_t RST_PRESENCE    = 10'd70;
  localparam cfg_word_t RST_RECOVERY    = 10'd410;
  localparam cfg_word_t RST_SHORT_LOW   = 10'd6;
  localparam cfg_word_t RST_ZERO_LOW    = 10'd60;
  localparam cfg_word_t RST_READ_SAMPLE = 10'd15;
  localparam cfg_word_t RST_SLOT        = 10'd70;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       line_level;
  } tick_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;
    logic       rejected;
  } res_t;

endpackage

FILE: sv/owm_cfg.sv
module owm_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [owm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output owm_pkg::cfg_t             cfg
);

  owm_pkg::cfg_t    cfg_r;
  logic             wr_en;
  logic [2:0]       idx;
  owm_pkg::cfg_word_t rd_word;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_idle_time      <= owm_pkg::RST_RESET_IDLE;
      cfg_r.reset_low_time       <= owm_pkg::RST_RESET_LOW;
      cfg_r.presence_sample_time <= owm_pkg::RST_PRESENCE;
      cfg_r.reset_recovery_time  <= owm_pkg::RST_RECOVERY;
      cfg_r.short_low_time       <= owm_pkg::RST_SHORT_LOW;
      cfg_r.zero_low_time        <= owm_pkg::RST_ZERO_LOW;
      cfg_r.read_sample_time     <= owm_pkg::RST_READ_SAMPLE;
      cfg_r.slot_time            <= owm_pkg::RST_SLOT;
    end else if (wr_en) begin
      unique case (idx)
        owm_pkg::REG_RESET_IDLE:  cfg_r.reset_idle_time      <= pwdata[owm_pkg::CFG_W-1:0];
        owm_pkg::REG_RESET_LOW:   cfg_r.reset_low_time       <= pwdata[owm_pkg::CFG_W-1:0];
        owm_pkg::REG_PRESENCE:    cfg_r.presence_sample_time <= pwdata[owm_pkg::CFG_W-1:0];
        owm_pkg::REG_RECOVERY:    cfg_r.reset_recovery_time  <= pwdata[owm_pkg::CFG_W-1:0];
        owm_pkg::REG_SHORT_LOW:   cfg_r.short_low_time       <= pwdata[owm_pkg::CFG_W-1:0];
        owm_pkg::REG_ZERO_LOW:    cfg_r.zero_low_time        <= pwdata[owm_pkg::CFG_W-1:0];
        owm_pkg::REG_READ_SAMPLE: cfg_r.read_sample_time     <= pwdata[owm_pkg::CFG_W-1:0];
        default:                  cfg_r.slot_time            <= pwdata[owm_pkg::CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      owm_pkg::REG_RESET_IDLE:  rd_word = cfg_r.reset_idle_time;
      owm_pkg::REG_RESET_LOW:   rd_word = cfg_r.reset_low_time;
      owm_pkg::REG_PRESENCE:    rd_word = cfg_r.presence_sample_time;
      owm_pkg::REG_RECOVERY:    rd_word = cfg_r.reset_recovery_time;
      owm_pkg::REG_SHORT_LOW:   rd_word = cfg_r.short_low_time;
      owm_pkg::REG_ZERO_LOW:    rd_word = cfg_r.zero_low_time;
      owm_pkg::REG_READ_SAMPLE: rd_word = cfg_r.read_sample_time;
      default:                  rd_word = cfg_r.slot_time;
    endcase
  end

  assign prdata = {{(32 - owm_pkg::CFG_W){1'b0}}, rd_word};

endmodule

FILE: sv/owm_core.sv
module owm_core #(
  parameter int TIMER_BITS = owm_pkg::TIMER_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  owm_pkg::tick_t tick,
  input  owm_pkg::cfg_t  cfg,
  output owm_pkg::res_t  res
);

  localparam int LEN_W = (TIMER_BITS >= owm_pkg::CFG_W) ? TIMER_BITS + 1 : owm_pkg::CFG_W;
  localparam logic [LEN_W-1:0] SPAN_MAX = LEN_W'(1) << TIMER_BITS;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_RIDLE  = 3'd1;
  localparam logic [2:0] PH_RLOW   = 3'd2;
  localparam logic [2:0] PH_RWAIT  = 3'd3;
  localparam logic [2:0] PH_RRECOV = 3'd4;
  localparam logic [2:0] PH_SLOT   = 3'd5;

  logic [2:0]            phase_r, phase_nxt;
  logic [1:0]            op_r, op_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic [2:0]            bit_r, bit_nxt;
  logic [7:0]            shift_r, shift_nxt;
  logic                  pres_r, pres_nxt;

  logic [LEN_W-1:0]      len;
  logic [LEN_W-1:0]      tmr_x;
  logic [LEN_W-1:0]      low_x;
  logic [LEN_W-1:0]      sp_x;
  logic                  last;

  function automatic logic [LEN_W-1:0] span(input owm_pkg::cfg_word_t v);
    logic [LEN_W-1:0] vx;
    vx = LEN_W'(v);
    if (vx == '0) return LEN_W'(1);
    if (vx > SPAN_MAX) return SPAN_MAX;
    return vx;
  endfunction

  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    timer_nxt = timer_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    pres_nxt  = pres_r;
    res       = '0;
    len       = LEN_W'(1);
    low_x     = '0;
    sp_x      = '0;
    tmr_x     = '0;
    last      = 1'b0;

    if (phase_r != PH_IDLE) begin
      res.rejected = (tick.command != owm_pkg::CMD_NONE);
    end else if (tick.command != owm_pkg::CMD_NONE) begin
      op_nxt    = tick.command;
      timer_nxt = '0;
      bit_nxt   = '0;
      if (tick.command == owm_pkg::CMD_RESET) begin
        phase_nxt = PH_RIDLE;
        pres_nxt  = 1'b0;
        shift_nxt = '0;
      end else begin
        phase_nxt = PH_SLOT;
        shift_nxt = (tick.command == owm_pkg::CMD_WRITE) ? tick.data_byte : 8'd0;
      end
    end

    if (phase_nxt != PH_IDLE) begin
      res.busy_res = 1'b1;
      tmr_x        = LEN_W'(timer_nxt);
      unique case (phase_nxt)
        PH_RIDLE: len = span(cfg.reset_idle_time);
        PH_RLOW: begin
          len           = span(cfg.reset_low_time);
          res.drive_low = 1'b1;
        end
        PH_RWAIT: len = span(cfg.presence_sample_time);
        PH_RRECOV: begin
          len = span(cfg.reset_recovery_time);
          if (timer_nxt == '0) pres_nxt = !tick.line_level;
        end
        default: begin
          len = span(cfg.slot_time);
          if (op_nxt == owm_pkg::CMD_WRITE && !shift_nxt[0]) low_x = LEN_W'(cfg.zero_low_time);
          else low_x = LEN_W'(cfg.short_low_time);
          if (tmr_x < low_x) res.drive_low = 1'b1;
          sp_x = LEN_W'(cfg.read_sample_time);
          if (sp_x > len - LEN_W'(1)) sp_x = len - LEN_W'(1);
          if (op_nxt == owm_pkg::CMD_READ && tmr_x == sp_x)
            shift_nxt = {tick.line_level, shift_nxt[7:1]};
        end
      endcase

      last = (tmr_x + LEN_W'(1)) >= len;
      if (!last) begin
        timer_nxt = timer_nxt + TIMER_BITS'(1);
      end else begin
        timer_nxt = '0;
        unique case (phase_nxt)
          PH_RIDLE:  phase_nxt = PH_RLOW;
          PH_RLOW:   phase_nxt = PH_RWAIT;
          PH_RWAIT:  phase_nxt = PH_RRECOV;
          PH_RRECOV: begin
            res.done_res = 1'b1;
            res.presence = pres_nxt;
            phase_nxt    = PH_IDLE;
          end
          default: begin
            if (op_nxt == owm_pkg::CMD_WRITE) shift_nxt = {1'b0, shift_nxt[7:1]};
            if (bit_nxt == 3'd7) begin
              res.done_res = 1'b1;
              if (op_nxt == owm_pkg::CMD_READ) res.read_byte = shift_nxt;
              bit_nxt   = '0;
              phase_nxt = PH_IDLE;
            end else begin
              bit_nxt = bit_nxt + 3'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      op_r    <= '0;
      timer_r <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      pres_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      timer_r <= timer_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      pres_r  <= pres_nxt;
    end
  end

endmodule

FILE: sv/onewire_bus_master.sv
// 1-Wire bus master driven by a stream of microsecond ticks.
// Input channel: one beat per bus tick. in_tuser carries the command
// (none, bus reset, write byte, read byte); in_tdata carries the byte to
// write and the sampled line level. Output channel: one beat per input
// beat with drive_low, busy, done, presence, read byte and rejected.
// A tick is registered on input and its result is registered on output,
// so a result beat is offered once its tick has stepped the sequencer.
// Throughput: one beat per cycle while the receiver does not stall; the
// step logic (timer compare and next-state selection) fits between the
// two registers.
// A command while an operation runs is dropped and flagged as rejected.
// If the receiver stalls, the output register holds its beat and the
// input register takes one more tick; in_tready then falls until the
// output drains. No beat is lost or repeated.
// Reset (rst_n low, synchronous) returns the sequencer to idle, empties both
// registers and restores the timing registers to their defaults. Timing registers
// are written over the APB port by the user only while the bus is idle (not enforced).
module onewire_bus_master #(
  parameter int TIMER_BITS = owm_pkg::TIMER_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [15:0]                in_tdata,   // data_byte[7:0], line_level[8], zero pad
  input  logic [1:0]                 in_tuser,   // command[1:0]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // drive_low[0], busy_res[1], done_res[2], presence[3], read_byte[11:4], rejected[12]
  output logic [15:0]                out_tdata,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [owm_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  owm_pkg::cfg_t  cfg;
  owm_pkg::tick_t tick_r;
  owm_pkg::res_t  res;
  owm_pkg::res_t  res_r;
  logic           in_valid_r;
  logic           out_valid_r;
  logic           adv;
  logic           step;

  owm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  owm_core #(.TIMER_BITS(TIMER_BITS)) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .tick  (tick_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign adv       = !out_valid_r || out_tready;
  assign step      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      tick_r.command    <= in_tuser;
      tick_r.data_byte  <= in_tdata[7:0];
      tick_r.line_level <= in_tdata[8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.rejected, res_r.read_byte, res_r.presence,
                       res_r.done_res, res_r.busy_res, res_r.drive_low};

endmodule

FILE: tb/tb_top.sv
module tb_top;

  localparam int STALL_LIMIT = 3000;
  localparam int TB_SPAN     = 1 << owm_pkg::TIMER_BITS_DEF;

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [15:0]                in_tdata;   // data_byte[7:0], line_level[8], zero pad
  logic [1:0]                 in_tuser;   // command[1:0]
  logic                       out_tvalid;
  logic                       out_tready;
  // drive_low[0], busy_res[1], done_res[2], presence[3], read_byte[11:4], rejected[12]
  logic [15:0]                out_tdata;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [owm_pkg::ADDR_W-1:0] cfg_paddr;
  logic [31:0]                cfg_pwdata;
  logic [31:0]                cfg_prdata;
  logic                       cfg_pready;

  bit no_gaps;
  int n_results;
  int n_ticks;
  int n_settings;

  onewire_bus_master dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Tick-level model of the bus sequencer plus the queue of result beats it owes.
  class owm_bus_tracker;
    typedef enum logic [2:0] {
      BUS_IDLE, RST_IDLE, RST_LOW, RST_WAIT, RST_RECOV, BIT_SLOT
    } bus_phase_e;

    owm_pkg::cfg_word_t timing [owm_pkg::NUM_REGS];
    bus_phase_e         ph;
    logic [1:0]         op;
    int unsigned        timer;
    int unsigned        bidx;
    logic [7:0]         shreg;
    logic               pres_flag;
    owm_pkg::res_t      due [$];
    int                 errors;
    int                 checked;
    int                 started [4];
    int                 rejects;

    function new();
      timing[owm_pkg::REG_RESET_IDLE]  = owm_pkg::RST_RESET_IDLE;
      timing[owm_pkg::REG_RESET_LOW]   = owm_pkg::RST_RESET_LOW;
      timing[owm_pkg::REG_PRESENCE]    = owm_pkg::RST_PRESENCE;
      timing[owm_pkg::REG_RECOVERY]    = owm_pkg::RST_RECOVERY;
      timing[owm_pkg::REG_SHORT_LOW]   = owm_pkg::RST_SHORT_LOW;
      timing[owm_pkg::REG_ZERO_LOW]    = owm_pkg::RST_ZERO_LOW;
      timing[owm_pkg::REG_READ_SAMPLE] = owm_pkg::RST_READ_SAMPLE;
      timing[owm_pkg::REG_SLOT]        = owm_pkg::RST_SLOT;
      ph        = BUS_IDLE;
      op        = owm_pkg::CMD_NONE;
      timer     = 0;
      bidx      = 0;
      shreg     = '0;
      pres_flag = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, owm_pkg::cfg_word_t val);
      timing[idx] = val;
    endfunction

    function bit idle();
      return ph == BUS_IDLE;
    endfunction

    // zero acts as one tick, clamp to timer range
    function int unsigned span(owm_pkg::cfg_word_t v);
      if (v == 0) return 1;
      if (int'(v) > TB_SPAN) return TB_SPAN;
      return v;
    endfunction

    function void take_tick(logic [1:0] cmd, logic [7:0] data, logic line);
      owm_pkg::res_t r;
      int unsigned   len;
      int unsigned   low;
      int unsigned   sp;
      r   = '0;
      len = 1;
      if (ph != BUS_IDLE) begin
        if (cmd != owm_pkg::CMD_NONE) begin
          r.rejected = 1'b1;
          rejects++;
        end
      end else if (cmd != owm_pkg::CMD_NONE) begin
        started[cmd]++;
        op    = cmd;
        timer = 0;
        bidx  = 0;
        if (cmd == owm_pkg::CMD_RESET) begin
          ph        = RST_IDLE;
          pres_flag = 1'b0;
          shreg     = '0;
        end else begin
          ph    = BIT_SLOT;
          shreg = (cmd == owm_pkg::CMD_WRITE) ? data : 8'h00;
        end
      end

      if (ph != BUS_IDLE) begin
        r.busy_res = 1'b1;
        case (ph)
          RST_IDLE: len = span(timing[owm_pkg::REG_RESET_IDLE]);
          RST_LOW: begin
            len = span(timing[owm_pkg::REG_RESET_LOW]);
            r.drive_low = 1'b1;
          end
          RST_WAIT: len = span(timing[owm_pkg::REG_PRESENCE]);
          RST_RECOV: begin
            len = span(timing[owm_pkg::REG_RECOVERY]);
            if (timer == 0) pres_flag = ~line;
          end
          default: begin
            len = span(timing[owm_pkg::REG_SLOT]);
            low = (op == owm_pkg::CMD_WRITE && !shreg[0]) ?
                  timing[owm_pkg::REG_ZERO_LOW] : timing[owm_pkg::REG_SHORT_LOW];
            if (timer < low) r.drive_low = 1'b1;
            sp = timing[owm_pkg::REG_READ_SAMPLE];
            if (sp > len - 1) sp = len - 1;
            if (op == owm_pkg::CMD_READ && timer == sp) shreg = {line, shreg[7:1]};
          end
        endcase

        if (timer + 1 < len) begin
          timer++;
        end else begin
          timer = 0;
          case (ph)
            RST_IDLE: ph = RST_LOW;
            RST_LOW:  ph = RST_WAIT;
            RST_WAIT: ph = RST_RECOV;
            RST_RECOV: begin
              r.done_res = 1'b1;
              r.presence = pres_flag;
              ph = BUS_IDLE;
            end
            default: begin
              if (op == owm_pkg::CMD_WRITE) shreg = shreg >> 1;
              if (bidx >= 7) begin
                r.done_res = 1'b1;
                if (op == owm_pkg::CMD_READ) r.read_byte = shreg;
                bidx = 0;
                ph = BUS_IDLE;
              end else begin
                bidx++;
              end
            end
          endcase
        end
      end
      due.push_back(r);
    endfunction

    function void match_beat(logic [15:0] beat);
      owm_pkg::res_t got;
      owm_pkg::res_t want;
      got.drive_low = beat[0];
      got.busy_res  = beat[1];
      got.done_res  = beat[2];
      got.presence  = beat[3];
      got.read_byte = beat[11:4];
      got.rejected  = beat[12];
      checked++;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("beat %0d: no result expected, got %h", checked, beat);
        return;
      end
      want = due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"beat %0d: expected drv=%b busy=%b done=%b pres=%b byte=%h rej=%b,",
                    " got drv=%b busy=%b done=%b pres=%b byte=%h rej=%b"},
                   checked, want.drive_low, want.busy_res, want.done_res, want.presence,
                   want.read_byte, want.rejected, got.drive_low, got.busy_res,
                   got.done_res, got.presence, got.read_byte, got.rejected);
      end
    endfunction
  endclass

  owm_bus_tracker sb = new();

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic send_tick(input logic [1:0] cmd, input logic [7:0] data, input logic line);
    while (!no_gaps && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, line, data};
    do @(posedge clk); while (!in_tready);
    sb.take_tick(cmd, data, line);
    n_ticks++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input owm_pkg::cfg_word_t val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, val);
  endtask

  task automatic program_timing(input owm_pkg::cfg_word_t r_idle,
                                input owm_pkg::cfg_word_t r_low,
                                input owm_pkg::cfg_word_t r_pres,
                                input owm_pkg::cfg_word_t r_recov,
                                input owm_pkg::cfg_word_t s_low,
                                input owm_pkg::cfg_word_t z_low,
                                input owm_pkg::cfg_word_t rd_pt,
                                input owm_pkg::cfg_word_t slot);
    write_reg(owm_pkg::REG_RESET_IDLE, r_idle);
    write_reg(owm_pkg::REG_RESET_LOW, r_low);
    write_reg(owm_pkg::REG_PRESENCE, r_pres);
    write_reg(owm_pkg::REG_RECOVERY, r_recov);
    write_reg(owm_pkg::REG_SHORT_LOW, s_low);
    write_reg(owm_pkg::REG_ZERO_LOW, z_low);
    write_reg(owm_pkg::REG_READ_SAMPLE, rd_pt);
    write_reg(owm_pkg::REG_SLOT, slot);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    n_settings++;
  endtask

  // mostly well-formed: start a command when idle, occasional stray command while busy
  task automatic run_random(input int n, input bit allow_reset);
    logic [1:0] cmd;
    repeat (n) begin
      if (sb.idle()) begin
        if ($urandom_range(99) < 15) cmd = owm_pkg::CMD_NONE;
        else cmd = 2'($urandom_range(allow_reset ? 1 : 2, 3));
      end else begin
        cmd = ($urandom_range(99) < 6) ? 2'($urandom_range(1, 3)) : owm_pkg::CMD_NONE;
      end
      send_tick(cmd, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  // finish the bus operation, then let every result beat come back
  task automatic settle();
    logic [1:0] cmd;
    while (!sb.idle()) begin
      cmd = ($urandom_range(99) < 3) ? 2'($urandom_range(1, 3)) : owm_pkg::CMD_NONE;
      send_tick(cmd, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
    in_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver: random back-pressure plus one long hold-off
  initial begin
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.match_beat(out_tdata);
        n_results++;
        if (n_results == 300) hold = 250;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_gaps || ($urandom_range(99) >= 26);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", quiet);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] pattern;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = owm_pkg::CMD_NONE;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    rst_n       = 1'b0;
    no_gaps     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_tick(owm_pkg::CMD_NONE, 8'h00, 1'b0);
    send_tick(owm_pkg::CMD_NONE, 8'hFF, 1'b1);
    settle();

    // one-tick phases and slots, zero-length idle phase, no low pulse on write-0
    program_timing(10'd0, 10'd1, 10'd1, 10'd1, 10'd1, 10'd0, 10'd0, 10'd1);
    // reset with a device answering, stray command on the done tick
    send_tick(owm_pkg::CMD_RESET, 8'h00, 1'b0);
    send_tick(owm_pkg::CMD_NONE, 8'h00, 1'b0);
    send_tick(owm_pkg::CMD_NONE, 8'h00, 1'b0);
    send_tick(owm_pkg::CMD_READ, 8'h00, 1'b0);
    // reset with no device
    for (int i = 0; i < 4; i++)
      send_tick(i == 0 ? owm_pkg::CMD_RESET : owm_pkg::CMD_NONE, 8'hFF, 1'b1);
    for (int i = 0; i < 8; i++)
      send_tick(i == 0 ? owm_pkg::CMD_WRITE :
                (i == 3 ? owm_pkg::CMD_RESET : owm_pkg::CMD_NONE), 8'h00, 1'b1);
    pattern = 8'hC5;
    for (int i = 0; i < 8; i++)
      send_tick(i == 0 ? owm_pkg::CMD_READ : owm_pkg::CMD_NONE, 8'hFF, pattern[i]);
    send_tick(owm_pkg::CMD_WRITE, 8'hFF, 1'b0);
    settle();

    program_timing(10'd3, 10'd5, 10'd4, 10'd6, 10'd2, 10'd8, 10'd4, 10'd10);
    run_random(300, 1'b1);
    settle();

    program_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
    run_random(130, 1'b1);
    settle();

    // short low pulse longer than the slot, sample point past the slot end
    program_timing(10'd1, 10'd2, 10'd1, 10'd2, 10'd9, 10'd3, 10'd12, 10'd7);
    run_random(180, 1'b1);
    settle();

    // largest pulse and sample values against a two-tick slot
    program_timing(10'd2, 10'd3, 10'd1, 10'd2,
                   10'd1023, 10'd1023, 10'd1023, 10'd2);
    send_tick(owm_pkg::CMD_RESET, 8'($urandom_range(255)), 1'b0);
    settle();
    run_random(70, 1'b0);
    settle();

    no_gaps = 1'b1;
    program_timing(10'd2, 10'd3, 10'd2, 10'd4, 10'd1, 10'd5, 10'd2, 10'd6);
    run_random(280, 1'b1);
    settle();
    no_gaps = 1'b0;

    $display("%0d ticks over %0d timing settings: %0d resets, %0d writes, %0d reads,",
             n_ticks, n_settings, sb.started[owm_pkg::CMD_RESET],
             sb.started[owm_pkg::CMD_WRITE], sb.started[owm_pkg::CMD_READ]);
    $display("%0d stray commands rejected, %0d result beats checked, %0d errors",
             sb.rejects, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/owm_pkg.sv
sv/owm_cfg.sv
sv/owm_core.sv
sv/onewire_bus_master.sv
tb/tb_top.sv
